@@ design/idb_pkg.sv @@
package idb_pkg;

    localparam int CHANNELS = 4;
    localparam int WINDOW   = 16;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int CMP_W  = CNT_W + 2;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] CNT_INIT_LOW = CNT_W'(WINDOW);
    localparam logic [CNT_W-1:0] CNT_CAP      = CNT_W'(WINDOW - 1);
    localparam logic [CMP_W-1:0] LOW_THR      = CMP_W'(WINDOW);
    localparam logic [CMP_W-1:0] HIGH_THR     = CMP_W'(3 * WINDOW);

    localparam logic [CHANNELS-1:0] RESET_ACTIVE_LOW = CHANNELS'(12);
    localparam logic [CHANNELS-1:0] RESET_FORWARD    = CHANNELS'(3);

    typedef enum logic {
        REG_ACTIVE_LOW = 1'b0,
        REG_FORWARD    = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic changed;
        logic state;
    } t_lane_res;

endpackage

@@ design/idb_in_if.sv @@
interface idb_in_if import idb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CHANNELS-1:0] pin_levels;

    modport source (output valid, output pin_levels, input ready);
    modport sink   (input valid, input pin_levels, output ready);
endinterface

@@ design/idb_out_if.sv @@
interface idb_out_if import idb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     channel;
    logic                new_state;
    logic [CHANNELS-1:0] active_mask;
    logic                forward_hit;
    logic                backward_hit;
    logic                last;

    modport source (
        output valid, output channel, output new_state, output active_mask,
        output forward_hit, output backward_hit, output last, input ready
    );
    modport sink (
        input valid, input channel, input new_state, input active_mask,
        input forward_hit, input backward_hit, input last, output ready
    );
endinterface

@@ design/idb_lane.sv @@
module idb_lane import idb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_load,
    input  logic      i_load_low,
    input  logic      i_step,
    input  logic      i_active_low,
    input  logic      i_level,
    output t_lane_res o_res
);

    logic [CNT_W-1:0] r_cnt;
    logic             r_state;
    logic [CNT_W-1:0] n_cnt;
    logic             n_state;
    logic [CMP_W-1:0] w_scaled;

    always_comb begin
        n_cnt = r_cnt;
        if (i_level) begin
            if (r_cnt < CNT_CAP) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
        w_scaled = {n_cnt, 2'b00};
        if (i_active_low) begin
            n_state = (w_scaled < LOW_THR);
        end else begin
            n_state = (w_scaled >= HIGH_THR);
        end
    end

    assign o_res.changed = (n_state != r_state);
    assign o_res.state   = n_state;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cnt   <= i_load_low ? CNT_INIT_LOW : '0;
            r_state <= 1'b0;
        end else if (i_step) begin
            r_cnt   <= n_cnt;
            r_state <= n_state;
        end
    end

endmodule

@@ design/idb_merge.sv @@
module idb_merge import idb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [CHANNELS-1:0] i_changed,
    input  logic [CHANNELS-1:0] i_state,
    input  logic [CHANNELS-1:0] i_forward,
    output logic                o_free,
    idb_out_if.source           o_out
);

    logic [CHANNELS-1:0] r_pend;
    logic [CHANNELS-1:0] r_act;
    logic                r_fwd;
    logic                r_bwd;
    logic                r_out_valid;
    logic [CH_W-1:0]     r_channel;
    logic                r_new_state;
    logic [CHANNELS-1:0] r_active_mask;
    logic                r_fwd_hit;
    logic                r_bwd_hit;
    logic                r_last;

    logic [CHANNELS-1:0] w_pick;
    logic [CHANNELS-1:0] w_rest;
    logic [CH_W-1:0]     w_idx;
    logic                w_adv;
    logic                w_rest_empty;

    always_comb begin
        w_pick = r_pend & (~r_pend + CHANNELS'(1));
        w_rest = r_pend & ~w_pick;
        w_idx  = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (w_pick[i]) begin
                w_idx = w_idx | CH_W'(i);
            end
        end
    end

    assign w_adv        = !r_out_valid || o_out.ready;
    assign w_rest_empty = (w_rest == '0);
    assign o_free       = (r_pend == '0) || (w_adv && w_rest_empty);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= (r_pend != '0);
            end
            if (i_step) begin
                r_pend <= i_changed;
            end else if (w_adv) begin
                r_pend <= w_rest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_act <= i_state;
            r_fwd <= |(i_changed & i_state & i_forward);
            r_bwd <= |(i_changed & i_state & ~i_forward);
        end
        if (w_adv && (r_pend != '0)) begin
            r_channel     <= w_idx;
            r_new_state   <= |(w_pick & r_act);
            r_active_mask <= r_act;
            r_last        <= w_rest_empty;
            r_fwd_hit     <= w_rest_empty && r_fwd;
            r_bwd_hit     <= w_rest_empty && r_bwd;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.channel      = r_channel;
    assign o_out.new_state    = r_new_state;
    assign o_out.active_mask  = r_active_mask;
    assign o_out.forward_hit  = r_fwd_hit;
    assign o_out.backward_hit = r_bwd_hit;
    assign o_out.last         = r_last;

endmodule

@@ design/integrating_debounce_multichannel_top.sv @@
// The first result of a tick passes through the pending register and then the output register.
// Throughput: a tick with k changed channels holds the input until its last result is issued,
// one result per cycle while the output is not stalled; at best one tick per cycle.
// Reset (synchronous, active low): active_low_mask 12, forward_mask 3, counters at WINDOW
// for active-low channels and 0 otherwise, all debounced states false, no results pending.
module integrating_debounce_multichannel_top import idb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    idb_in_if.sink            i_in,
    idb_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [CHANNELS-1:0] r_active_low;
    logic [CHANNELS-1:0] r_forward;

    t_reg_idx            w_reg;
    logic                w_wr;
    logic                w_load;
    logic [CHANNELS-1:0] w_load_low;
    logic                w_step;
    logic                w_free;
    t_lane_res           w_lane [CHANNELS];
    logic [CHANNELS-1:0] w_changed;
    logic [CHANNELS-1:0] w_state;

    assign w_reg      = t_reg_idx'(paddr[2]);
    assign w_wr       = psel && penable && pwrite;
    assign pready     = 1'b1;
    assign w_load     = !i_rst_n || (w_wr && (w_reg == REG_ACTIVE_LOW));
    assign w_load_low = !i_rst_n ? RESET_ACTIVE_LOW : pwdata[CHANNELS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_low <= RESET_ACTIVE_LOW;
            r_forward    <= RESET_FORWARD;
        end else if (w_wr) begin
            case (w_reg)
                REG_ACTIVE_LOW: r_active_low <= pwdata[CHANNELS-1:0];
                REG_FORWARD:    r_forward    <= pwdata[CHANNELS-1:0];
                default:        r_forward    <= r_forward;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_ACTIVE_LOW: prdata = DATA_W'(r_active_low);
            REG_FORWARD:    prdata = DATA_W'(r_forward);
            default:        prdata = '0;
        endcase
    end

    assign i_in.ready = w_free;
    assign w_step     = i_in.valid && w_free;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        idb_lane u_lane (
            .i_clk        (i_clk),
            .i_load       (w_load),
            .i_load_low   (w_load_low[g]),
            .i_step       (w_step),
            .i_active_low (r_active_low[g]),
            .i_level      (i_in.pin_levels[g]),
            .o_res        (w_lane[g])
        );
        assign w_changed[g] = w_lane[g].changed;
        assign w_state[g]   = w_lane[g].state;
    end

    idb_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_changed (w_changed),
        .i_state   (w_state),
        .i_forward (r_forward),
        .o_free    (w_free),
        .o_out     (o_out)
    );

    a_mask_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.active_mask[o_out.channel] == o_out.new_state))
        else $error("result state disagrees with its mask bit");

    a_hits_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last) |-> (!o_out.forward_hit && !o_out.backward_hit))
        else $error("hit flag on a result that is not last");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=> o_out.valid)
        else $error("result run broken before its last result");

    a_no_accept_midrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready && !o_out.last) |-> !i_in.ready)
        else $error("tick request taken while a stalled run is pending");

endmodule

@@ tb/tb_integrating_debounce_multichannel_top.sv @@
module tb_integrating_debounce_multichannel_top;
    timeunit 1ns;
    timeprecision 1ps;
    import idb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int CHOKE_LEN   = 300;
    localparam int IDLE_PCT    = 18;
    localparam int SETTLE      = 4;

    typedef struct packed {
        logic [CH_W-1:0]     channel;
        logic                new_state;
        logic [CHANNELS-1:0] active_mask;
        logic                forward_hit;
        logic                backward_hit;
        logic                last;
    } t_flip;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    idb_in_if  tick_bus ();
    idb_out_if flip_bus ();

    integrating_debounce_multichannel_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_bus),
        .o_out   (flip_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [CHANNELS-1:0] tick_q [$];
    t_flip               flip_q [$];

    int                  lvl_cnt [CHANNELS];
    logic [CHANNELS-1:0] deb_st;
    logic [CHANNELS-1:0] low_mask_m;
    logic [CHANNELS-1:0] fwd_mask_m;

    logic calm;
    logic choke_arm;
    logic choke_done;
    int   choke_len   = 0;
    int   cycles      = 0;
    int   errors      = 0;
    int   ticks_taken = 0;
    int   flips_seen  = 0;
    int   quad_ticks  = 0;
    int   polarities  = 1;

    function automatic void reload_levels();
        for (int c = 0; c < CHANNELS; c++) begin
            lvl_cnt[c] = low_mask_m[c] ? WINDOW : 0;
        end
        deb_st = '0;
    endfunction

    function automatic void debounce_tick(input logic [CHANNELS-1:0] pins);
        int    moved [$];
        logic  nxt;
        logic  fh;
        logic  bh;
        t_flip f;
        fh = 1'b0;
        bh = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (pins[c]) begin
                if (lvl_cnt[c] + 1 < WINDOW) lvl_cnt[c]++;
            end else if (lvl_cnt[c] > 0) begin
                lvl_cnt[c]--;
            end
            nxt = low_mask_m[c] ? (lvl_cnt[c] * 4 < WINDOW) : (lvl_cnt[c] * 4 >= 3 * WINDOW);
            if (nxt != deb_st[c]) begin
                deb_st[c] = nxt;
                moved = {moved, c};
                if (nxt) begin
                    if (fwd_mask_m[c]) fh = 1'b1;
                    else bh = 1'b1;
                end
            end
        end
        if (moved.size() == CHANNELS) quad_ticks++;
        foreach (moved[k]) begin
            f.channel      = CH_W'(moved[k]);
            f.new_state    = deb_st[moved[k]];
            f.active_mask  = deb_st;
            f.last         = (k == moved.size() - 1);
            f.forward_hit  = f.last & fh;
            f.backward_hit = f.last & bh;
            flip_q = {flip_q, f};
        end
    endfunction

    task automatic report_miss(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        errors++;
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [CHANNELS-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ACTIVE_LOW) begin
            low_mask_m = val;
            reload_levels();
            polarities++;
        end else begin
            fwd_mask_m = val;
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (tick_q.size() != 0 || tick_bus.valid || flip_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic load_random(input int n);
        logic [CHANNELS-1:0] lean;
        logic [CHANNELS-1:0] pins;
        lean = CHANNELS'($urandom);
        repeat (n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if ($urandom_range(11) == 0) lean[c] = ~lean[c];
                pins[c] = lean[c] ^ ($urandom_range(99) < 8);
            end
            if ($urandom_range(9) == 0) pins = CHANNELS'($urandom);
            tick_q = {tick_q, pins};
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending", cycles, flip_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_bus.valid      <= 1'b0;
            tick_bus.pin_levels <= '0;
        end else if (!tick_bus.valid || tick_bus.ready) begin
            if (tick_bus.valid) begin
                debounce_tick(tick_q.pop_front());
                ticks_taken++;
            end
            if (tick_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                tick_bus.valid      <= 1'b1;
                tick_bus.pin_levels <= tick_q[0];
            end else begin
                tick_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            choke_len  <= 0;
            choke_done <= 1'b0;
        end else if (choke_arm && !choke_done) begin
            choke_len <= choke_len + 1;
            if (choke_len == CHOKE_LEN - 1) choke_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : flip_mon
        t_flip want;
        if (!i_rst_n) begin
            flip_bus.ready <= 1'b0;
        end else begin
            if (flip_bus.valid && flip_bus.ready) begin
                flips_seen++;
                if (flip_q.size() == 0) begin
                    report_miss($sformatf("unexpected result for channel %0d", flip_bus.channel));
                end else begin
                    want = flip_q.pop_front();
                    if (flip_bus.channel !== want.channel)
                        report_miss($sformatf("channel got %0d want %0d",
                                              flip_bus.channel, want.channel));
                    if (flip_bus.new_state !== want.new_state)
                        report_miss($sformatf("new_state ch%0d got %0b want %0b",
                                              want.channel, flip_bus.new_state, want.new_state));
                    if (flip_bus.active_mask !== want.active_mask)
                        report_miss($sformatf("active_mask ch%0d got %h want %h",
                                              want.channel, flip_bus.active_mask,
                                              want.active_mask));
                    if (flip_bus.forward_hit !== want.forward_hit)
                        report_miss($sformatf("forward_hit ch%0d got %0b want %0b",
                                              want.channel, flip_bus.forward_hit,
                                              want.forward_hit));
                    if (flip_bus.backward_hit !== want.backward_hit)
                        report_miss($sformatf("backward_hit ch%0d got %0b want %0b",
                                              want.channel, flip_bus.backward_hit,
                                              want.backward_hit));
                    if (flip_bus.last !== want.last)
                        report_miss($sformatf("last ch%0d got %0b want %0b",
                                              want.channel, flip_bus.last, want.last));
                end
            end
            flip_bus.ready <= !(choke_arm && !choke_done) &&
                              (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        calm                = 1'b0;
        choke_arm           = 1'b0;
        low_mask_m          = RESET_ACTIVE_LOW;
        fwd_mask_m          = RESET_FORWARD;
        reload_levels();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // count up the forward pair while the pull-up pair counts down, then drop all pins, then raise them all
        repeat (12) tick_q = {tick_q, 4'b0011};
        tick_q = {tick_q, 4'b0000};
        tick_q = {tick_q, 4'b1111};
        load_random(60);
        drain();

        reg_write(REG_ACTIVE_LOW, 4'b1111);
        reg_write(REG_FORWARD, 4'b0000);
        calm <= 1'b1;
        tick_q = {tick_q, 4'b1111};
        tick_q = {tick_q, 4'b1111};
        load_random(70);
        drain();

        calm <= 1'b0;
        reg_write(REG_ACTIVE_LOW, 4'b0000);
        reg_write(REG_FORWARD, 4'b1111);
        choke_arm <= 1'b1;
        load_random(80);
        drain();

        // keep counters and states, swap only the facing
        reg_write(REG_FORWARD, 4'b0101);
        load_random(70);
        drain();

        repeat (3) begin
            reg_write(REG_ACTIVE_LOW, CHANNELS'($urandom));
            reg_write(REG_FORWARD, CHANNELS'($urandom));
            load_random(70);
            drain();
        end
        repeat (SETTLE) @(negedge i_clk);

        $display("%0d sample ticks over %0d polarity settings, %0d state changes checked",
                 ticks_taken, polarities, flips_seen);
        $display("%0d ticks flipped every channel, output held off for %0d cycles",
                 quad_ticks, choke_len);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/idb_pkg.sv
design/idb_in_if.sv
design/idb_out_if.sv
design/idb_lane.sv
design/idb_merge.sv
design/integrating_debounce_multichannel_top.sv
tb/tb_integrating_debounce_multichannel_top.sv
